// ===== hw/rtl/bgdtd_pkg.sv =====
// shared types and constants for the banded gram product block
`default_nettype none

package bgdtd_pkg;

  localparam int MAX_BAND_DEF    = 8;
  localparam int COLUMN_BITS_DEF = 16;
  localparam int COEF_W          = 32;
  localparam int VALUE_W         = 64;
  localparam int BAND_CFG_W      = 4;

  localparam logic [BAND_CFG_W-1:0] BAND_RESET = 4'd3;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic                     final_coef;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] band_value;
    logic [2:0]                band_row;
    logic [15:0]               band_column;
    logic                      run_last;
  } out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bgdtd_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none

module bgdtd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bgdtd_mac.sv =====
// multiply and saturating accumulate pipeline for window updates
`default_nettype none

module bgdtd_mac import bgdtd_pkg::*; #(
  parameter int AW = 6
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      issue,
  input  wire logic [AW-1:0]             issue_addr,
  input  wire logic                      issue_hit,
  input  wire logic signed [COEF_W-1:0]  coef,
  input  wire logic signed [COEF_W-1:0]  rb_data,
  input  wire logic [VALUE_W-1:0]        acc_data,
  output logic                           wr_en,
  output logic [AW-1:0]                  wr_addr,
  output logic [VALUE_W-1:0]             wr_data,
  output logic                           busy
);

  logic                       s1_v_r, s2_v_r;
  logic [AW-1:0]              s1_addr_r, s2_addr_r;
  logic                       s1_hit_r;
  logic signed [VALUE_W-1:0]  prod_nxt, prod_r;
  logic signed [VALUE_W-1:0]  acc_nxt, acc_r;
  logic signed [VALUE_W-1:0]  sum;
  logic                       ovf;

  assign prod_nxt = coef * rb_data;
  assign acc_nxt  = s1_hit_r ? $signed(acc_data) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= issue_addr;
    s1_hit_r  <= issue_hit;
    s2_addr_r <= s1_addr_r;
    prod_r    <= prod_nxt;
    acc_r     <= acc_nxt;
  end

  assign sum = acc_r + prod_r;
  assign ovf = (acc_r[VALUE_W-1] == prod_r[VALUE_W-1]) && (sum[VALUE_W-1] != acc_r[VALUE_W-1]);

  always_comb begin
    if (!ovf) begin
      wr_data = sum;
    end else if (acc_r[VALUE_W-1]) begin
      wr_data = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      wr_data = {1'b0, {(VALUE_W-1){1'b1}}};
    end
  end

  assign wr_en   = s2_v_r;
  assign wr_addr = s2_addr_r;
  assign busy    = s1_v_r | s2_v_r;

endmodule

`default_nettype wire

// ===== hw/rtl/banded_gram_dt_d_accumulate.sv =====
// top level of the streamed banded gram product block
`default_nettype none

// Takes the coefficients of a banded matrix one request at a time and returns the finished
// band columns of its gram product, each column as band_size results in offset order. A
// coefficient at position k of its row (counting from 0) costs k+1 steps of the single shared
// multiplier, which reads the row buffer memory and the accumulator window memory once per
// step, followed by the pipeline drain. A request that completes a row then yields band_size
// results, each through a window read, a load and a handshake that waits while out_ready is
// low; on the final row band_size columns are emitted. No new request is taken until all
// results of the current one are delivered. Window entries carry valid bits in flip-flops,
// so reset and the end of a flush clear the window at once without a clearing pass.
module banded_gram_dt_d_accumulate import bgdtd_pkg::*; #(
  parameter int MAX_BAND    = MAX_BAND_DEF,
  parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [BAND_CFG_W-1:0] cfg_wdata
);

  localparam int IW    = (MAX_BAND > 1) ? $clog2(MAX_BAND) : 1;
  localparam int DEPTH = MAX_BAND * MAX_BAND;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IW:0]           MB_W   = (IW+1)'(MAX_BAND);
  localparam logic [BAND_CFG_W-1:0] MB_CFG = BAND_CFG_W'(MAX_BAND);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MAC   = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_RD    = 6'b001000,
    ST_LD    = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [BAND_CFG_W-1:0]    band_r, band_nxt;
  logic [IW-1:0]            pos_r, pos_nxt;
  logic [IW-1:0]            head_r, head_nxt;
  logic [COLUMN_BITS-1:0]   row_cnt_r, row_cnt_nxt;
  logic [IW-1:0]            q_r, q_nxt;
  logic [IW-1:0]            p_r, p_nxt;
  logic [IW-1:0]            r_r, r_nxt;
  logic [IW-1:0]            col_r, col_nxt;
  logic                     final_r, final_nxt;
  logic                     comp_r, comp_nxt;
  logic [DEPTH-1:0]         hit_r, hit_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     emit_hit_r, emit_hit_nxt;
  logic signed [COEF_W-1:0] coef_r, coef_nxt;
  out_t                     out_r, out_nxt;

  logic [BAND_CFG_W-1:0]    b_eff, b_last;
  logic                     complete;
  logic                     issue;
  logic [AW-1:0]            mac_addr, emit_addr, acc_raddr;
  logic                     acc_re;
  logic signed [COEF_W-1:0] rb_rdata;
  logic [VALUE_W-1:0]       acc_rdata;
  logic                     mac_wr_en, mac_busy;
  logic [AW-1:0]            mac_wr_addr;
  logic [VALUE_W-1:0]       mac_wr_data;

  function automatic logic [IW-1:0] slot_add(logic [IW-1:0] a, logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= MB_W) begin
      s = s - MB_W;
    end
    return s[IW-1:0];
  endfunction

  function automatic logic [AW-1:0] addr_of(logic [IW-1:0] slot, logic [IW-1:0] off);
    return AW'(slot) * AW'(MAX_BAND) + AW'(off);
  endfunction

  always_comb begin
    if (band_r == '0) begin
      b_eff = BAND_CFG_W'(1);
    end else if (band_r > MB_CFG) begin
      b_eff = MB_CFG;
    end else begin
      b_eff = band_r;
    end
  end

  assign b_last    = b_eff - BAND_CFG_W'(1);
  assign complete  = (BAND_CFG_W'(pos_r) >= b_last) || in_data.final_coef;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign issue     = (state_r == ST_MAC);
  assign mac_addr  = addr_of(slot_add(head_r, p_r), q_r - p_r);
  assign emit_addr = addr_of(head_r, r_r);
  assign acc_raddr = issue ? mac_addr : emit_addr;
  assign acc_re    = issue || (state_r == ST_RD);

  bgdtd_ram #(.WIDTH(COEF_W), .DEPTH(MAX_BAND)) u_row_ram (
    .clk   (clk),
    .we    (in_valid && in_ready),
    .waddr (pos_r),
    .wdata (in_data.coef),
    .re    (issue),
    .raddr (p_r),
    .rdata (rb_rdata)
  );

  bgdtd_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_acc_ram (
    .clk   (clk),
    .we    (mac_wr_en),
    .waddr (mac_wr_addr),
    .wdata (mac_wr_data),
    .re    (acc_re),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  bgdtd_mac #(.AW(AW)) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue),
    .issue_addr (mac_addr),
    .issue_hit  (hit_r[mac_addr]),
    .coef       (coef_r),
    .rb_data    (rb_rdata),
    .acc_data   (acc_rdata),
    .wr_en      (mac_wr_en),
    .wr_addr    (mac_wr_addr),
    .wr_data    (mac_wr_data),
    .busy       (mac_busy)
  );

  always_comb begin
    state_nxt     = state_r;
    band_nxt      = band_r;
    pos_nxt       = pos_r;
    head_nxt      = head_r;
    row_cnt_nxt   = row_cnt_r;
    q_nxt         = q_r;
    p_nxt         = p_r;
    r_nxt         = r_r;
    col_nxt       = col_r;
    final_nxt     = final_r;
    comp_nxt      = comp_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r;
    emit_hit_nxt  = emit_hit_r;
    coef_nxt      = coef_r;
    out_nxt       = out_r;

    if (cfg_we) begin
      band_nxt = cfg_wdata;
    end
    if (mac_wr_en) begin
      hit_nxt[mac_wr_addr] = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          coef_nxt  = in_data.coef;
          final_nxt = in_data.final_coef;
          comp_nxt  = complete;
          q_nxt     = pos_r;
          p_nxt     = '0;
          pos_nxt   = complete ? '0 : IW'(pos_r + 1'b1);
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (p_r == q_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          p_nxt = IW'(p_r + 1'b1);
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          r_nxt     = '0;
          col_nxt   = '0;
          state_nxt = comp_r ? ST_RD : ST_IDLE;
        end
      end
      ST_RD: begin
        emit_hit_nxt = hit_r[emit_addr];
        state_nxt    = ST_LD;
      end
      ST_LD: begin
        out_nxt.band_value  = emit_hit_r ? $signed(acc_rdata) : '0;
        out_nxt.band_row    = 3'(r_r);
        out_nxt.band_column = 16'(row_cnt_r);
        out_nxt.run_last    = (BAND_CFG_W'(r_r) == b_last)
                              && (!final_r || (BAND_CFG_W'(col_r) == b_last));
        out_valid_nxt       = 1'b1;
        state_nxt           = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (BAND_CFG_W'(r_r) < b_last) begin
            r_nxt     = IW'(r_r + 1'b1);
            state_nxt = ST_RD;
          end else begin
            // column done: drop its slot and move the window on
            for (int i = 0; i < DEPTH; i++) begin
              if ((i / MAX_BAND) == int'(head_r)) begin
                hit_nxt[i] = 1'b0;
              end
            end
            head_nxt    = slot_add(head_r, IW'(1));
            row_cnt_nxt = row_cnt_r + 1'b1;
            if (final_r && (BAND_CFG_W'(col_r) < b_last)) begin
              col_nxt   = IW'(col_r + 1'b1);
              r_nxt     = '0;
              state_nxt = ST_RD;
            end else begin
              if (final_r) begin
                hit_nxt     = '0;
                head_nxt    = '0;
                row_cnt_nxt = '0;
              end
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      band_r      <= BAND_RESET;
      pos_r       <= '0;
      head_r      <= '0;
      row_cnt_r   <= '0;
      q_r         <= '0;
      p_r         <= '0;
      r_r         <= '0;
      col_r       <= '0;
      final_r     <= 1'b0;
      comp_r      <= 1'b0;
      hit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      band_r      <= band_nxt;
      pos_r       <= pos_nxt;
      head_r      <= head_nxt;
      row_cnt_r   <= row_cnt_nxt;
      q_r         <= q_nxt;
      p_r         <= p_nxt;
      r_r         <= r_nxt;
      col_r       <= col_nxt;
      final_r     <= final_nxt;
      comp_r      <= comp_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    emit_hit_r <= emit_hit_nxt;
    coef_r     <= coef_nxt;
    out_r      <= out_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bgdtd_checker.sv =====
// port level checks for the banded gram product block, with bind
`default_nettype none

module bgdtd_checker import bgdtd_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no request is taken while a result is pending
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request taken with result pending");

  // an accepted request drops in_ready in the cycle after it
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a request");

  // last result of a request frees the block at once
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.run_last |=> in_ready && !out_valid)
    else $error("block not idle after last result");

endmodule

bind banded_gram_dt_d_accumulate bgdtd_checker u_bgdtd_checker (.*);

`default_nettype wire
